/* rtl/pfa_pkg.sv */
// Shared types and codes for the partition fit allocator.
`default_nettype none

package pfa_pkg;

   // table depth; index and count fields on the ports are sized for it
   localparam int MAX_PARTS = 16;

   // operation codes carried in req_tuser
   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_REQUEST = 2'd1,
      OP_FREE    = 2'd2,
      OP_MERGE   = 2'd3
   } op_type;

   // result status codes carried in rsp_tuser
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NOFIT  = 2'd1,
      ST_ERROR  = 2'd2
   } status_type;

   // fit policy register codes; the unused code behaves as first fit
   localparam logic [1:0] POL_BEST  = 2'd0;
   localparam logic [1:0] POL_FIRST = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SEARCH,
      FSM_COMMIT,
      FSM_MERGE,
      FSM_MERGE_WB,
      FSM_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture the word and run append or free
      logic read_en;   // issue a table read at the scan pointer
      logic commit;    // write back the chosen entry of a request
      logic merge_wb;  // write the last merged entry and the new count
      logic rsp_load;  // move the result into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_end;  // every entry below the count has been read
      logic rd_vld;    // read data is being evaluated this cycle
      logic cnt_zero;  // table is empty
   } sts_type;

endpackage

`default_nettype wire

/* rtl/pfa_datapath.sv */
// Partition table memories, scan logic and result registers.
`default_nettype none

module pfa_datapath #(
   parameter int SIZE_BITS = 16
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_we,
   input  wire  [1:0]              csr_wdata,
   input  wire  [1:0]              op,
   input  wire  [15:0]             req_size,
   input  wire  [3:0]              entry_index,
   input  wire  pfa_pkg::cmd_type  cmd,
   output pfa_pkg::sts_type        sts,
   output logic [1:0]              rsp_status,
   output logic [3:0]              rsp_chosen,
   output logic [4:0]              rsp_entries
);

   localparam int IDX_W = $clog2(pfa_pkg::MAX_PARTS);
   localparam int CNT_W = $clog2(pfa_pkg::MAX_PARTS + 1);

   logic [1:0]           policy_ff;
   logic [1:0]           op_ff;
   logic [SIZE_BITS-1:0] amt_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     rd_ptr_ff;
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     data_idx_ff;
   logic [SIZE_BITS-1:0] rd_size_ff;
   logic [SIZE_BITS-1:0] rd_used_ff;
   logic                 found_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic [SIZE_BITS-1:0] best_free_ff;
   logic [SIZE_BITS-1:0] best_used_ff;
   logic [IDX_W-1:0]     w_ptr_ff;
   logic [SIZE_BITS-1:0] cache_size_ff;
   logic [SIZE_BITS-1:0] cache_used_ff;
   logic [1:0]           res_status_ff;
   logic [3:0]           res_chosen_ff;
   logic [4:0]           res_count_ff;
   logic [1:0]           rsp_status_ff;
   logic [3:0]           rsp_chosen_ff;
   logic [4:0]           rsp_entries_ff;

   logic [SIZE_BITS-1:0] mem_size_ff [pfa_pkg::MAX_PARTS];
   logic [SIZE_BITS-1:0] mem_used_ff [pfa_pkg::MAX_PARTS];

   logic [SIZE_BITS-1:0] amt_in;
   logic                 room;
   logic                 idx_ok;
   logic [SIZE_BITS-1:0] free_cur;
   logic                 fits;
   logic                 take;
   logic                 eval_req;
   logic                 eval_merge;
   logic                 merge_join;
   logic                 merge_adv;
   logic [SIZE_BITS:0]   sum_wide;
   logic [SIZE_BITS-1:0] merged_size;
   logic [CNT_W-1:0]     w_count;

   logic                 size_we;
   logic                 used_we;
   logic [IDX_W-1:0]     wr_addr;
   logic [SIZE_BITS-1:0] wr_size;
   logic [SIZE_BITS-1:0] wr_used;
   logic [IDX_W-1:0]     rd_addr;

   assign amt_in  = SIZE_BITS'(req_size);
   assign room    = (32'(cnt_ff) < pfa_pkg::MAX_PARTS);
   assign idx_ok  = (32'(entry_index) < 32'(cnt_ff));
   assign rd_addr = rd_ptr_ff[IDX_W-1:0];
   assign w_count = CNT_W'(w_ptr_ff) + CNT_W'(1);

   assign free_cur   = rd_size_ff - rd_used_ff;
   assign fits       = (free_cur >= amt_ff);
   assign eval_req   = rd_vld_ff && (op_ff == pfa_pkg::OP_REQUEST);
   assign eval_merge = rd_vld_ff && (op_ff == pfa_pkg::OP_MERGE);
   assign merge_join = (cache_used_ff == '0) && (rd_used_ff == '0);
   assign merge_adv  = eval_merge && (data_idx_ff != '0) && !merge_join;

   assign sum_wide    = {1'b0, cache_size_ff} + {1'b0, rd_size_ff};
   assign merged_size = sum_wide[SIZE_BITS] ? '1 : sum_wide[SIZE_BITS-1:0];

   // later entry wins ties in best and worst fit
   always_comb begin
      unique case (policy_ff)
         pfa_pkg::POL_BEST:  take = fits && (!found_ff || (best_free_ff >= free_cur));
         pfa_pkg::POL_WORST: take = fits && (!found_ff || (best_free_ff <= free_cur));
         default:            take = fits && !found_ff;
      endcase
   end

   // single write port into the table
   always_comb begin
      size_we = 1'b0;
      used_we = 1'b0;
      wr_addr = w_ptr_ff;
      wr_size = cache_size_ff;
      wr_used = cache_used_ff;
      priority if (cmd.load) begin
         if ((op == pfa_pkg::OP_APPEND) && room) begin
            size_we = 1'b1;
            used_we = 1'b1;
            wr_addr = cnt_ff[IDX_W-1:0];
            wr_size = amt_in;
            wr_used = '0;
         end else if ((op == pfa_pkg::OP_FREE) && idx_ok) begin
            used_we = 1'b1;
            wr_addr = IDX_W'(entry_index);
            wr_used = '0;
         end
      end else if (cmd.commit && found_ff) begin
         used_we = 1'b1;
         wr_addr = best_idx_ff;
         wr_used = best_used_ff + amt_ff;
      end else if (cmd.merge_wb || merge_adv) begin
         size_we = 1'b1;
         used_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (size_we) begin
         mem_size_ff[wr_addr] <= wr_size;
      end
      if (used_we) begin
         mem_used_ff[wr_addr] <= wr_used;
      end
      if (cmd.read_en) begin
         rd_size_ff <= mem_size_ff[rd_addr];
         rd_used_ff <= mem_used_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= pfa_pkg::POL_FIRST;
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            policy_ff <= csr_wdata;
         end
         rd_vld_ff <= cmd.read_en;
         if (cmd.load && (op == pfa_pkg::OP_APPEND) && room) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (cmd.merge_wb) begin
            cnt_ff <= w_count;
         end
      end
   end

   // scan, search and merge state
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= op;
         amt_ff    <= amt_in;
         rd_ptr_ff <= '0;
         found_ff  <= 1'b0;
         w_ptr_ff  <= '0;
      end else if (cmd.read_en) begin
         rd_ptr_ff <= rd_ptr_ff + CNT_W'(1);
      end
      if (cmd.read_en) begin
         data_idx_ff <= rd_addr;
      end
      if (eval_req && take) begin
         found_ff     <= 1'b1;
         best_idx_ff  <= data_idx_ff;
         best_free_ff <= free_cur;
         best_used_ff <= rd_used_ff;
      end
      if (eval_merge) begin
         if (data_idx_ff == '0) begin
            cache_size_ff <= rd_size_ff;
            cache_used_ff <= rd_used_ff;
         end else if (merge_join) begin
            cache_size_ff <= merged_size;
         end else begin
            w_ptr_ff      <= w_ptr_ff + IDX_W'(1);
            cache_size_ff <= rd_size_ff;
            cache_used_ff <= rd_used_ff;
         end
      end
   end

   // result of the current word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         unique case (op)
            pfa_pkg::OP_APPEND: begin
               res_status_ff <= room ? pfa_pkg::ST_OK : pfa_pkg::ST_ERROR;
               res_chosen_ff <= room ? 4'(cnt_ff) : 4'd0;
               res_count_ff  <= room ? 5'(cnt_ff + CNT_W'(1)) : 5'(cnt_ff);
            end
            pfa_pkg::OP_FREE: begin
               res_status_ff <= idx_ok ? pfa_pkg::ST_OK : pfa_pkg::ST_ERROR;
               res_chosen_ff <= '0;
               res_count_ff  <= 5'(cnt_ff);
            end
            default: begin
               res_status_ff <= pfa_pkg::ST_OK;
               res_chosen_ff <= '0;
               res_count_ff  <= 5'(cnt_ff);
            end
         endcase
      end else if (cmd.commit) begin
         if (found_ff) begin
            res_chosen_ff <= 4'(best_idx_ff);
         end else begin
            res_status_ff <= pfa_pkg::ST_NOFIT;
         end
      end else if (cmd.merge_wb) begin
         res_count_ff <= 5'(w_count);
      end
      if (cmd.rsp_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_chosen_ff  <= res_chosen_ff;
         rsp_entries_ff <= res_count_ff;
      end
   end

   assign sts.scan_end = (rd_ptr_ff == cnt_ff);
   assign sts.rd_vld   = rd_vld_ff;
   assign sts.cnt_zero = (cnt_ff == '0);

   assign rsp_status  = rsp_status_ff;
   assign rsp_chosen  = rsp_chosen_ff;
   assign rsp_entries = rsp_entries_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= pfa_pkg::MAX_PARTS)
      else $error("entry count above table depth");

   a_merge_order: assert property (@(posedge clock) disable iff (reset)
      (eval_merge && (data_idx_ff != '0)) |-> (w_ptr_ff < data_idx_ff))
      else $error("merge write pointer caught up with read");

   a_commit_found: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && found_ff) |=> (res_status_ff == pfa_pkg::ST_OK))
      else $error("fitting request not reported done");

endmodule

`default_nettype wire

/* rtl/pfa_controller.sv */
// Sequencing state machine and output word valid for the allocator.
`default_nettype none

module pfa_controller (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire  [1:0]              op,
   input  wire  pfa_pkg::sts_type  sts,
   output pfa_pkg::cmd_type        cmd,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready
);

   pfa_pkg::state_type state_ff;
   pfa_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               accept;
   logic               out_free;

   assign accept   = req_tvalid && (state_ff == pfa_pkg::FSM_IDLE);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfa_pkg::FSM_IDLE: begin
            if (accept) begin
               if (op == pfa_pkg::OP_REQUEST) begin
                  state_in = pfa_pkg::FSM_SEARCH;
               end else if ((op == pfa_pkg::OP_MERGE) && !sts.cnt_zero) begin
                  state_in = pfa_pkg::FSM_MERGE;
               end else begin
                  state_in = pfa_pkg::FSM_DONE;
               end
            end
         end
         pfa_pkg::FSM_SEARCH: begin
            if (sts.scan_end && !sts.rd_vld) begin
               state_in = pfa_pkg::FSM_COMMIT;
            end
         end
         pfa_pkg::FSM_COMMIT: begin
            state_in = pfa_pkg::FSM_DONE;
         end
         pfa_pkg::FSM_MERGE: begin
            if (sts.scan_end && !sts.rd_vld) begin
               state_in = pfa_pkg::FSM_MERGE_WB;
            end
         end
         pfa_pkg::FSM_MERGE_WB: begin
            state_in = pfa_pkg::FSM_DONE;
         end
         pfa_pkg::FSM_DONE: begin
            if (out_free) begin
               state_in = pfa_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = pfa_pkg::FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         pfa_pkg::FSM_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = accept;
         end
         pfa_pkg::FSM_SEARCH, pfa_pkg::FSM_MERGE: begin
            cmd.read_en = !sts.scan_end;
         end
         pfa_pkg::FSM_COMMIT: begin
            cmd.commit = 1'b1;
         end
         pfa_pkg::FSM_MERGE_WB: begin
            cmd.merge_wb = 1'b1;
         end
         pfa_pkg::FSM_DONE: begin
            cmd.rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfa_pkg::FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("output word overwritten before taken");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == pfa_pkg::FSM_DONE) && !out_free) |=> (state_ff == pfa_pkg::FSM_DONE))
      else $error("left done state with output still full");

endmodule

`default_nettype wire

/* rtl/partition_fit_allocator.sv */
// A result loads into the output register in the done state: append, free and
// empty merge reach it straight from accept, a request by way of search and commit,
// a merge over entries by way of merge and merge write-back (one table read per
// scan cycle); rsp_tvalid rises with that load. The next word is accepted only once
// it is back in idle after the load; a result not yet taken holds the next one's load.
// Synchronous active-high reset empties the table, sets first fit, drops rsp_tvalid.
`default_nettype none

module partition_fit_allocator #(
   parameter int SIZE_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire  [1:0]  csr_wdata,     // fit_policy
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,     // req_size[15:0], entry_index[19:16], zero pad
   input  wire  [1:0]  req_tuser,     // op
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,     // chosen_index[3:0], entries_now[8:4], zero pad
   output logic [1:0]  rsp_tuser      // status
);

   pfa_pkg::cmd_type cmd;
   pfa_pkg::sts_type sts;
   logic [3:0]       rsp_chosen;
   logic [4:0]       rsp_entries;

   pfa_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .op         (req_tuser),
      .sts        (sts),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   pfa_datapath #(
      .SIZE_BITS (SIZE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .op          (req_tuser),
      .req_size    (req_tdata[15:0]),
      .entry_index (req_tdata[19:16]),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_status  (rsp_tuser),
      .rsp_chosen  (rsp_chosen),
      .rsp_entries (rsp_entries)
   );

   assign rsp_tdata = {7'd0, rsp_entries, rsp_chosen};

endmodule

`default_nettype wire
